FILE: src/sbpr_pkg.sv
// ----------------------------------------------------------------------------
// sbpr_pkg
// Shared constants and types for the servo bus packet receiver.
// ----------------------------------------------------------------------------
package sbpr_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned LEN_W      = 9;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned CSR_ADDR_W = 3;

   localparam logic [BYTE_W-1:0] HEADER_BYTE      = 8'hFF;
   localparam logic [LEN_W-1:0]  MIN_LENGTH_RESET = 9'd6;
   localparam logic [LEN_W-1:0]  LENGTH_OFFSET    = 9'd4;

   // packet positions with special handling
   localparam logic [LEN_W-1:0]  POS_HEADER_END = 9'd2;
   localparam logic [LEN_W-1:0]  POS_ID         = 9'd2;
   localparam logic [LEN_W-1:0]  POS_LENGTH     = 9'd3;
   localparam logic [LEN_W-1:0]  POS_INSTR      = 9'd4;

   // register index decoded from paddr[2]
   localparam logic REG_MIN_LENGTH = 1'b0;

   typedef struct packed {
      logic              stored;
      logic [LEN_W-1:0]  position;
      logic [BYTE_W-1:0] data_byte;
      logic              packet_done;
      logic              checksum_ok;
      logic [LEN_W-1:0]  packet_length;
      logic [BYTE_W-1:0] packet_id;
      logic [BYTE_W-1:0] instruction;
   } result_type;

endpackage

FILE: src/servo_bus_packet_receiver_core.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_receiver_core
// Byte-wise packet parser: FF FF id len instr params checksum, with running
// inverted-sum checksum and minimum length filter.
// ----------------------------------------------------------------------------
//  channel  | ports   | direction | content
//  ---------+---------+-----------+-------------------------------------------
//  request  | req_*   | in        | one received byte per word
//  response | rsp_*   | out       | one result word per byte
//  csr      | csr_*   | in/out    | APB-style access to min_length
//
//  One byte is taken per cycle; its result word is registered and appears
//  the cycle after acceptance. Throughput is one word per cycle, set by the
//  single pass through the parser state update.
//  Reset (synchronous, active high) clears the parser state and the result
//  valid flag and sets min_length to 6.
//  A stalled response holds the result register and blocks further bytes;
//  a new byte is taken in the same cycle the waiting result is taken.
// ----------------------------------------------------------------------------
module servo_bus_packet_receiver_core (
   input  logic                                  clock,
   input  logic                                  reset,
   // request
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [sbpr_pkg::BYTE_W-1:0]           req_byte_in,
   // response
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_stored,
   output logic [sbpr_pkg::LEN_W-1:0]            rsp_position,
   output logic [sbpr_pkg::BYTE_W-1:0]           rsp_data_byte,
   output logic                                  rsp_packet_done,
   output logic                                  rsp_checksum_ok,
   output logic [sbpr_pkg::LEN_W-1:0]            rsp_packet_length,
   output logic [sbpr_pkg::BYTE_W-1:0]           rsp_packet_id,
   output logic [sbpr_pkg::BYTE_W-1:0]           rsp_instruction,
   // configuration
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [sbpr_pkg::CSR_ADDR_W-1:0]       paddr,
   input  logic [sbpr_pkg::CSR_DATA_W-1:0]       pwdata,
   output logic [sbpr_pkg::CSR_DATA_W-1:0]       prdata,
   output logic                                  pready
);

   logic [sbpr_pkg::LEN_W-1:0]  min_length_ff, min_length_in;
   logic [sbpr_pkg::LEN_W-1:0]  count_ff, count_in;
   logic [sbpr_pkg::LEN_W-1:0]  exp_len_ff, exp_len_in;
   logic [sbpr_pkg::BYTE_W-1:0] sum_ff, sum_in;
   logic [sbpr_pkg::BYTE_W-1:0] held_id_ff, held_id_in;
   logic [sbpr_pkg::BYTE_W-1:0] held_ins_ff, held_ins_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   sbpr_pkg::result_type        result_ff, result_in;

   logic                        accept;
   logic                        csr_write;
   logic [sbpr_pkg::LEN_W-1:0]  next_count;
   logic [sbpr_pkg::BYTE_W-1:0] ins_cur;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // ---------------- configuration ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      min_length_in = min_length_ff;
      if (csr_write && paddr[2] == sbpr_pkg::REG_MIN_LENGTH) begin
         min_length_in = pwdata[sbpr_pkg::LEN_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == sbpr_pkg::REG_MIN_LENGTH) begin
         prdata = {{(sbpr_pkg::CSR_DATA_W-sbpr_pkg::LEN_W){1'b0}}, min_length_ff};
      end
   end

   // ---------------- parser ----------------
   assign next_count = count_ff + 9'd1;

   always_comb begin
      count_in     = count_ff;
      exp_len_in   = exp_len_ff;
      sum_in       = sum_ff;
      held_id_in   = held_id_ff;
      held_ins_in  = held_ins_ff;
      ins_cur      = held_ins_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;

      if (accept) begin
         rsp_valid_in            = 1'b1;
         result_in               = '0;
         result_in.data_byte     = req_byte_in;

         if (count_ff < sbpr_pkg::POS_HEADER_END) begin
            if (req_byte_in == sbpr_pkg::HEADER_BYTE) begin
               result_in.stored = 1'b1;
               count_in         = next_count;
            end else begin
               count_in = '0;
            end
         end else if (count_ff == sbpr_pkg::POS_ID) begin
            result_in.stored = 1'b1;
            held_id_in       = req_byte_in;
            sum_in           = req_byte_in;
            count_in         = next_count;
         end else if (count_ff == sbpr_pkg::POS_LENGTH) begin
            result_in.stored = 1'b1;
            exp_len_in       = {1'b0, req_byte_in} + sbpr_pkg::LENGTH_OFFSET;
            sum_in           = sum_ff + req_byte_in;
            count_in         = next_count;
         end else if (count_ff == sbpr_pkg::POS_INSTR && exp_len_ff < min_length_ff) begin
            // too short: drop, byte not stored
            count_in = '0;
         end else begin
            result_in.stored = 1'b1;
            if (count_ff == sbpr_pkg::POS_INSTR) begin
               held_ins_in = req_byte_in;
               ins_cur     = req_byte_in;
            end
            if (next_count >= exp_len_ff) begin
               result_in.packet_done   = 1'b1;
               result_in.checksum_ok   = (~sum_ff == req_byte_in);
               result_in.packet_length = (~sum_ff == req_byte_in) ? next_count : '0;
               result_in.packet_id     = held_id_ff;
               result_in.instruction   = ins_cur;
               count_in                = '0;
            end else begin
               sum_in   = sum_ff + req_byte_in;
               count_in = next_count;
            end
         end

         if (result_in.stored) begin
            result_in.position = count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_length_ff <= sbpr_pkg::MIN_LENGTH_RESET;
         count_ff      <= '0;
         exp_len_ff    <= '0;
         sum_ff        <= '0;
         held_id_ff    <= '0;
         held_ins_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         min_length_ff <= min_length_in;
         count_ff      <= count_in;
         exp_len_ff    <= exp_len_in;
         sum_ff        <= sum_in;
         held_id_ff    <= held_id_in;
         held_ins_ff   <= held_ins_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_stored        = result_ff.stored;
   assign rsp_position      = result_ff.position;
   assign rsp_data_byte     = result_ff.data_byte;
   assign rsp_packet_done   = result_ff.packet_done;
   assign rsp_checksum_ok   = result_ff.checksum_ok;
   assign rsp_packet_length = result_ff.packet_length;
   assign rsp_packet_id     = result_ff.packet_id;
   assign rsp_instruction   = result_ff.instruction;

   // ---------------- assertions ----------------
   a_done_is_stored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.packet_done |-> result_ff.stored)
      else $error("packet completion on a byte that was not stored");

   a_ok_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.checksum_ok |-> result_ff.packet_done)
      else $error("checksum status without packet completion");

   a_length_iff_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.packet_done |->
         ((result_ff.packet_length != '0) == result_ff.checksum_ok))
      else $error("packet length does not follow checksum status");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < 9'd259)
      else $error("byte count beyond largest packet");

   a_bad_header_resync: assert property (@(posedge clock) disable iff (reset)
      accept && count_ff < sbpr_pkg::POS_HEADER_END
         && req_byte_in != sbpr_pkg::HEADER_BYTE |=> count_ff == '0)
      else $error("bad header byte did not restart the parser");

endmodule

FILE: test/servo_bus_packet_receiver_core_test.sv
// ----------------------------------------------------------------------------
// servo_bus_packet_receiver_core_test
// Self-checking bench for the packet receiver. Bytes go in through the
// request channel with random gaps and every result word is checked field by
// field against a byte-wise parser model held here. The run covers header
// faults, length filtering, short and long packets, bad checksums,
// min_length settings and a long stall on the response side.
// ----------------------------------------------------------------------------
module servo_bus_packet_receiver_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [sbpr_pkg::BYTE_W-1:0] octet_type;
   typedef logic [sbpr_pkg::LEN_W-1:0]  count_type;

   logic                            clock;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   octet_type                       req_byte_in = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic                            rsp_stored;
   count_type                       rsp_position;
   octet_type                       rsp_data_byte;
   logic                            rsp_packet_done;
   logic                            rsp_checksum_ok;
   count_type                       rsp_packet_length;
   octet_type                       rsp_packet_id;
   octet_type                       rsp_instruction;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [sbpr_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [sbpr_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [sbpr_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   localparam logic [sbpr_pkg::CSR_ADDR_W-1:0] MIN_LENGTH_ADDR =
      {sbpr_pkg::REG_MIN_LENGTH, 2'b00};

   // parser model state
   count_type  min_len_cfg = sbpr_pkg::MIN_LENGTH_RESET;
   count_type  parse_count = '0;
   count_type  frame_length = '0;
   octet_type  csum_acc = '0;
   octet_type  frame_id = '0;
   octet_type  frame_instr = '0;

   sbpr_pkg::result_type expected_results[$];
   int         failures = 0;
   int         items_sent = 0;
   bit         no_idle = 1'b0;
   int         ready_hold = 0;

   servo_bus_packet_receiver_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_stored        (rsp_stored),
      .rsp_position      (rsp_position),
      .rsp_data_byte     (rsp_data_byte),
      .rsp_packet_done   (rsp_packet_done),
      .rsp_checksum_ok   (rsp_checksum_ok),
      .rsp_packet_length (rsp_packet_length),
      .rsp_packet_id     (rsp_packet_id),
      .rsp_instruction   (rsp_instruction),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("servo_bus_packet_receiver_core verification failed");
      $finish;
   end

   // one byte through the parser model; returns the word it should produce
   function sbpr_pkg::result_type parse_byte(input octet_type b);
      sbpr_pkg::result_type r;
      count_type  pos;
      count_type  nxt;
      r = '0;
      r.data_byte = b;
      pos = parse_count;
      if (pos < sbpr_pkg::POS_HEADER_END) begin
         if (b == sbpr_pkg::HEADER_BYTE) begin
            r.stored = 1'b1;
            r.position = pos;
            parse_count = pos + 1'b1;
         end else begin
            parse_count = '0;
         end
      end else if (pos == sbpr_pkg::POS_ID) begin
         r.stored = 1'b1;
         r.position = pos;
         frame_id = b;
         csum_acc = b;
         parse_count = sbpr_pkg::POS_LENGTH;
      end else if (pos == sbpr_pkg::POS_LENGTH) begin
         r.stored = 1'b1;
         r.position = pos;
         frame_length = {1'b0, b} + sbpr_pkg::LENGTH_OFFSET;
         csum_acc = csum_acc + b;
         parse_count = sbpr_pkg::POS_INSTR;
      end else if (pos == sbpr_pkg::POS_INSTR && frame_length < min_len_cfg) begin
         parse_count = '0;
      end else begin
         r.stored = 1'b1;
         r.position = pos;
         if (pos == sbpr_pkg::POS_INSTR) frame_instr = b;
         nxt = pos + 1'b1;
         if (nxt >= frame_length) begin
            r.packet_done = 1'b1;
            r.checksum_ok = (~csum_acc == b);
            r.packet_length = r.checksum_ok ? nxt : '0;
            r.packet_id = frame_id;
            r.instruction = frame_instr;
            parse_count = '0;
         end else begin
            parse_count = nxt;
            csum_acc = csum_acc + b;
         end
      end
      return r;
   endfunction

   // response side: random stalls, or a counted hold-off when asked
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold = ready_hold - 1;
      end else begin
         rsp_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 6);
      end
   end

   task automatic check_field(input string name, input logic [sbpr_pkg::LEN_W-1:0] want,
                              input logic [sbpr_pkg::LEN_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : result_monitor
      sbpr_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result word with nothing expected, expected none, actual byte %0d",
                     $time, rsp_data_byte);
            failures++;
         end else begin
            want = expected_results.pop_front();
            check_field("stored", want.stored, rsp_stored);
            check_field("position", want.position, rsp_position);
            check_field("data_byte", want.data_byte, rsp_data_byte);
            check_field("packet_done", want.packet_done, rsp_packet_done);
            check_field("checksum_ok", want.checksum_ok, rsp_checksum_ok);
            check_field("packet_length", want.packet_length, rsp_packet_length);
            check_field("packet_id", want.packet_id, rsp_packet_id);
            check_field("instruction", want.instruction, rsp_instruction);
         end
      end
   end

   // called at a clock edge; leaves valid high so a following word needs no gap
   task automatic send_byte(input octet_type b);
      if (!no_idle && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_in <= b;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(parse_byte(b));
      items_sent++;
   endtask

   task automatic send_list(input octet_type seq[$]);
      foreach (seq[i]) send_byte(seq[i]);
   endtask

   // sender stops and waits for every outstanding word
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [sbpr_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [sbpr_pkg::CSR_DATA_W-1:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= v;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read(input logic [sbpr_pkg::CSR_ADDR_W-1:0] addr,
                           output logic [sbpr_pkg::CSR_DATA_W-1:0] v);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= addr;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      v = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_min_length(input count_type v);
      csr_write(MIN_LENGTH_ADDR, {{(sbpr_pkg::CSR_DATA_W-sbpr_pkg::LEN_W){1'b0}}, v});
      min_len_cfg = v;
   endtask

   task automatic check_min_length_readback;
      logic [sbpr_pkg::CSR_DATA_W-1:0] v;
      csr_read(MIN_LENGTH_ADDR, v);
      if (v !== {{(sbpr_pkg::CSR_DATA_W-sbpr_pkg::LEN_W){1'b0}}, min_len_cfg}) begin
         $display("%0t: min_length readback mismatch, expected %0d, actual %0d",
                  $time, min_len_cfg, v);
         failures++;
      end
   endtask

   // one packet, a broken header or a little line noise
   task automatic send_random_packet;
      octet_type seq[$];
      octet_type id;
      octet_type len;
      octet_type chk;
      octet_type b;
      int     base;
      int     body;
      int     pick;
      int     extra;
      pick = $urandom_range(99);
      if (pick < 10) begin
         repeat ($urandom_range(1, 4)) seq.push_back(octet_type'($urandom_range(0, 255)));
      end else if (pick < 15) begin
         seq.push_back(sbpr_pkg::HEADER_BYTE);
         seq.push_back(octet_type'($urandom_range(0, 254)));
      end else begin
         base = (min_len_cfg > 259) ? 255 : ((min_len_cfg < 4) ? 0 : min_len_cfg - 4);
         pick = $urandom_range(99);
         extra = $urandom_range(0, 8);
         if (pick < 1) len = 8'd255;
         else if (pick < 15) len = octet_type'($urandom_range(0, 7));
         else len = octet_type'((base + extra > 255) ? 255 : base + extra);
         id = octet_type'($urandom_range(0, 255));
         seq.push_back(sbpr_pkg::HEADER_BYTE);
         seq.push_back(sbpr_pkg::HEADER_BYTE);
         seq.push_back(id);
         seq.push_back(len);
         chk = id + len;
         // instruction plus parameters; lengths 0 and 1 have the checksum at position 4
         body = (len == 0) ? 0 : len - 1;
         repeat (body) begin
            b = octet_type'($urandom_range(0, 255));
            seq.push_back(b);
            chk = chk + b;
         end
         chk = ~chk;
         if ($urandom_range(99) < 20) chk = chk ^ octet_type'($urandom_range(1, 255));
         seq.push_back(chk);
      end
      send_list(seq);
   endtask

   task automatic run_traffic(input int budget);
      int start;
      start = items_sent;
      while (items_sent - start < budget) send_random_packet();
      drain();
   endtask

   task automatic test_register_access;
      check_min_length_readback();
      set_min_length(9'd259);
      check_min_length_readback();
      set_min_length(sbpr_pkg::MIN_LENGTH_RESET);
   endtask

   task automatic test_framing_cases;
      // bad first header, bad second header, good packet, too short
      send_list('{8'h00, 8'hFF, 8'h00,
                  8'hFF, 8'hFF, 8'h01, 8'h02, 8'h03, 8'hF9,
                  8'hFF, 8'hFF, 8'hFE, 8'h01, 8'h55});
      drain();
   endtask

   task automatic test_very_short_packets;
      set_min_length(9'd4);
      // zero length byte, then a bad checksum on a length-2 packet
      send_list('{8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'hFF});
      drain();
   endtask

   task automatic test_random_traffic;
      set_min_length(sbpr_pkg::MIN_LENGTH_RESET);
      run_traffic(180);
      set_min_length(9'd4);
      no_idle = 1'b1;
      run_traffic(180);
      no_idle = 1'b0;
      set_min_length(9'd259);
      run_traffic(200);
      set_min_length(count_type'($urandom_range(4, 20)));
      run_traffic(180);
      // above the longest packet, so nothing gets past position 4
      set_min_length(9'd511);
      run_traffic(60);
      set_min_length(count_type'($urandom_range(5, 12)));
      run_traffic(180);
   endtask

   task automatic test_output_backpressure;
      set_min_length(sbpr_pkg::MIN_LENGTH_RESET);
      ready_hold = 50;
      run_traffic(60);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_framing_cases();
      test_very_short_packets();
      test_random_traffic();
      test_output_backpressure();
      drain();
      if (failures == 0 && expected_results.size() == 0) begin
         $display("servo_bus_packet_receiver_core verification clean");
      end else begin
         $display("servo_bus_packet_receiver_core verification failed");
      end
      $finish;
   end

endmodule
